>>> rtl/cmcm_pkg.sv
// ----------------------------------------------------------------------------
// Common-mode clipped mean package
// Shared item types, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package cmcm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MEAN_BITS   = 24;
    localparam int FRAC_BITS   = 8;
    localparam int KEPT_BITS   = 8;
    localparam int CFG_BITS    = 4;
    localparam int MAX_PASSES  = 8;

    // configuration register indexes
    localparam logic CFG_PASS_COUNT  = 1'b0;
    localparam logic CFG_CLIP_FACTOR = 1'b1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } t_in_item;

    typedef struct packed {
        logic [MEAN_BITS-1:0] common_mode;
        logic [KEPT_BITS-1:0] kept_count;
        logic                 overflow;
    } t_out_item;

endpackage

>>> rtl/cmcm_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmcm_div #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_dividend,
    input  logic [DEN_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [CNT_BITS-1:0] r_cnt;
    logic                r_run;
    logic                r_done;
    logic [DEN_BITS:0]   r_rem;
    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS:0]   w_trial;
    logic                w_fit;

    // shift in the next dividend bit and try a subtract
    assign w_trial = {r_rem[DEN_BITS-1:0], r_quo[NUM_BITS-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_BITS'(NUM_BITS);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_run) begin
            r_rem <= w_fit ? (w_trial - {1'b0, r_den}) : w_trial;
            r_quo <= {r_quo[NUM_BITS-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/common_mode_clipped_mean.sv
// ----------------------------------------------------------------------------
// Common-mode clipped mean
// Iterative sigma-clipped mean of one set of unsigned ADC samples.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-------------------------------
//  input     | start, busy                 | i_item  (sample, last)
//  result    | o_strobe, one cycle         | o_result (common_mode, kept,
//            |                             |           overflow)
//  config    | i_cfg_valid, o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Samples are taken one per cycle while loading. The item with last set
// starts the passes; each pass over L stored samples runs a sum, one
// divide on the bit-serial divider, a deviation sum and a clip test.
// busy stays high until the result strobe. Reset is synchronous; the
// sample store needs no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module common_mode_clipped_mean
    import cmcm_pkg::*;
#(
    parameter int MAX_SAMPLES = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_in_item      i_item,
    output logic          o_strobe,
    output t_out_item     o_result,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    localparam int SB       = SAMPLE_BITS;
    localparam int AW       = $clog2(MAX_SAMPLES);
    localparam int CW       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_BITS = SB + CW;
    localparam int QW       = SUM_BITS + FRAC_BITS;
    localparam int SQW      = 2 * SUM_BITS;
    localparam int DEVW     = SQW + CW;
    localparam int BW       = DEVW + 2 * CFG_BITS;
    localparam int PW       = $clog2(MAX_PASSES + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT, ST_PASS, ST_SUM_RD, ST_SUM_ACC, ST_DIV_GO, ST_DIV_WAIT,
        ST_EL_RD, ST_EL_DIFF, ST_EL_SQ, ST_EL_ACC, ST_BOUND, ST_EL_MULN, ST_EL_WB
    } t_state;

    t_state              r_state;
    logic [CFG_BITS-1:0] r_pass_cfg;
    logic [CFG_BITS-1:0] r_clip_cfg;
    logic [CW-1:0]       r_load_cnt;
    logic                r_ovf;
    logic [MEAN_BITS-1:0] r_mean;
    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_kept;
    logic [CW-1:0]       r_idx;
    logic [PW-1:0]       r_pass;
    logic [PW-1:0]       r_passes;
    logic                r_clip_phase;
    logic                r_strobe;
    t_out_item           r_result;

    logic [SUM_BITS-1:0] r_sum;
    logic [SUM_BITS-1:0] r_d;
    logic [SQW-1:0]      r_sq;
    logic [DEVW-1:0]     r_dev;
    logic [DEVW-1:0]     r_lhs;
    logic [BW-1:0]       r_bound;

    // sample store: keep flag on top of each sample
    logic [SB:0]         r_mem [MAX_SAMPLES];
    logic [SB:0]         r_rd;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [SB:0]         w_wdata;

    logic                w_accept;
    logic                w_div_done;
    logic [QW-1:0]       w_quo;
    logic                w_last_el;
    logic [SUM_BITS-1:0] w_nx;
    logic [PW-1:0]       w_passes;
    logic [CW+KEPT_BITS-1:0] w_kept_ext;
    logic [MEAN_BITS-1:0] w_mean_sat;

    assign w_accept    = start && !busy;
    assign busy        = r_state != ST_IDLE;
    assign o_cfg_ready = 1'b1;
    assign w_last_el   = (r_idx + 1'b1) == r_load_cnt;
    assign w_nx        = SUM_BITS'(r_n) * SUM_BITS'(r_rd[SB-1:0]);
    assign w_kept_ext  = (CW+KEPT_BITS)'(r_n);
    assign w_mean_sat  = (w_quo[QW-1:MEAN_BITS] != '0) ? '1 : w_quo[MEAN_BITS-1:0];

    // pass count: zero runs once, large values stop at the maximum
    always_comb begin
        if (r_pass_cfg == '0)
            w_passes = PW'(1);
        else if (r_pass_cfg > CFG_BITS'(MAX_PASSES))
            w_passes = PW'(MAX_PASSES);
        else
            w_passes = PW'(r_pass_cfg);
    end

    // store write port: loading, or clearing a keep flag
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = {1'b0, r_rd[SB-1:0]};
        if (w_accept && r_load_cnt < CW'(MAX_SAMPLES)) begin
            w_we    = 1'b1;
            w_waddr = r_load_cnt[AW-1:0];
            w_wdata = {1'b1, i_item.sample};
        end else if (r_state == ST_EL_WB && r_rd[SB] && !(BW'(r_lhs) < r_bound)) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we)
            r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_cfg <= CFG_BITS'(4);
            r_clip_cfg <= CFG_BITS'(3);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PASS_COUNT:  r_pass_cfg <= i_cfg_data;
                CFG_CLIP_FACTOR: r_clip_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cmcm_div #(
        .NUM_BITS (QW),
        .DEN_BITS (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DIV_GO),
        .i_dividend ({r_sum, FRAC_BITS'(0)}),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // sequencer with registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_load_cnt <= '0;
            r_ovf      <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (r_load_cnt < CW'(MAX_SAMPLES))
                            r_load_cnt <= r_load_cnt + 1'b1;
                        else
                            r_ovf <= 1'b1;
                        if (i_item.last)
                            r_state <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    r_n      <= r_load_cnt;
                    r_pass   <= '0;
                    r_passes <= w_passes;
                    r_mean   <= '0;
                    r_state  <= ST_PASS;
                end
                ST_PASS: begin
                    r_idx <= '0;
                    r_sum <= '0;
                    if (r_n == '0 || r_pass == r_passes) begin
                        r_strobe             <= 1'b1;
                        r_result.common_mode <= r_mean;
                        r_result.kept_count  <= (w_kept_ext > (CW+KEPT_BITS)'(255)) ?
                                                '1 : w_kept_ext[KEPT_BITS-1:0];
                        r_result.overflow    <= r_ovf;
                        r_load_cnt           <= '0;
                        r_ovf                <= 1'b0;
                        r_state              <= ST_IDLE;
                    end else begin
                        r_state <= ST_SUM_RD;
                    end
                end
                ST_SUM_RD: r_state <= ST_SUM_ACC;
                ST_SUM_ACC: begin
                    if (r_rd[SB])
                        r_sum <= r_sum + SUM_BITS'(r_rd[SB-1:0]);
                    if (w_last_el) begin
                        r_state <= ST_DIV_GO;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_SUM_RD;
                    end
                end
                ST_DIV_GO: r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_mean       <= w_mean_sat;
                        r_idx        <= '0;
                        r_dev        <= '0;
                        r_clip_phase <= 1'b0;
                        r_state      <= ST_EL_RD;
                    end
                end
                ST_EL_RD: r_state <= ST_EL_DIFF;
                // |n*x - S|
                ST_EL_DIFF: begin
                    r_d     <= (w_nx >= r_sum) ? (w_nx - r_sum) : (r_sum - w_nx);
                    r_state <= ST_EL_SQ;
                end
                ST_EL_SQ: begin
                    r_sq    <= SQW'(r_d) * SQW'(r_d);
                    r_state <= r_clip_phase ? ST_EL_MULN : ST_EL_ACC;
                end
                ST_EL_ACC: begin
                    if (r_rd[SB])
                        r_dev <= r_dev + DEVW'(r_sq);
                    if (w_last_el) begin
                        r_state <= ST_BOUND;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_EL_RD;
                    end
                end
                // k^2 times the deviation sum
                ST_BOUND: begin
                    r_bound      <= BW'(r_dev) *
                                    BW'({{CFG_BITS{1'b0}}, r_clip_cfg} *
                                        {{CFG_BITS{1'b0}}, r_clip_cfg});
                    r_idx        <= '0;
                    r_kept       <= '0;
                    r_clip_phase <= 1'b1;
                    r_state      <= ST_EL_RD;
                end
                ST_EL_MULN: begin
                    r_lhs   <= DEVW'(r_sq) * DEVW'(r_n);
                    r_state <= ST_EL_WB;
                end
                ST_EL_WB: begin
                    if (r_rd[SB] && BW'(r_lhs) < r_bound)
                        r_kept <= r_kept + 1'b1;
                    if (w_last_el) begin
                        r_state <= ST_PASS;
                        r_n     <= (r_rd[SB] && BW'(r_lhs) < r_bound) ?
                                   r_kept + 1'b1 : r_kept;
                        r_pass  <= r_pass + 1'b1;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_EL_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
